// File: src/two_tick_pattern_locator_defines.svh
// Assertion macros for the two-tick pattern locator checker.
`ifndef TWO_TICK_PATTERN_LOCATOR_DEFINES_SVH
`define TWO_TICK_PATTERN_LOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TTPL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("two_tick_pattern_locator check failed");

// Next-cycle implication, disabled while reset is high.
`define TTPL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("two_tick_pattern_locator check failed");

`endif

// File: src/ttpl_pkg.sv
// Shared constants for the two-tick pattern locator.
`timescale 1ns / 1ps
package ttpl_pkg;

   localparam int DEF_BUFFER_DEPTH = 65536;
   localparam int DEF_SAMPLE_BITS  = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_GAP  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN      = 2'd2;

   localparam logic [15:0] RST_TICK_GAP  = 16'd12000;
   localparam logic [14:0] RST_TOLERANCE = 15'd48;
   localparam logic        RST_GAIN      = 1'b1;

   localparam int POS_BITS = 17;
   localparam logic signed [POS_BITS-1:0] POS_NONE = -17'sd1;
   localparam logic signed [POS_BITS-1:0] POS_MAX  = 17'sd65535;

   // Threshold ratios: 9*m >= 7*peak with gain, 10*m >= 7*full_scale without.
   localparam int THR_NUM  = 7;
   localparam int GAIN_DEN = 9;
   localparam int ABS_DEN  = 10;

endpackage

// File: src/ttpl_reach.sv
// Threshold test of one stored sample against the peak or full scale.
`timescale 1ns / 1ps
module ttpl_reach
   import ttpl_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic        [SAMPLE_BITS-1:0] peak,
   input  logic                          gain,
   output logic                          reach
);

   localparam int MW = SAMPLE_BITS + 4;
   localparam logic [MW-1:0] ABS_LIMIT = MW'(THR_NUM) << (SAMPLE_BITS - 1);

   logic [SAMPLE_BITS-1:0] mag;
   logic [MW-1:0]          mag_gain;
   logic [MW-1:0]          mag_abs;
   logic [MW-1:0]          peak_scaled;

   assign mag         = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
   assign mag_gain    = MW'(mag) * MW'(GAIN_DEN);
   assign mag_abs     = MW'(mag) * MW'(ABS_DEN);
   assign peak_scaled = MW'(peak) * MW'(THR_NUM);
   assign reach       = gain ? (mag_gain >= peak_scaled) : (mag_abs >= ABS_LIMIT);

endmodule

// File: src/two_tick_pattern_locator.sv
// Top level of the two-tick pattern locator: sample store, prefix build and scan.
`timescale 1ns / 1ps
// Loading takes one request per cycle while not busy; the sample memory takes one
// write per cycle. After a request with last set: a setup state, then a build pass
// that fills the threshold prefix memory, then two scan states per tested position
// (two reads each from the prefix memory's two ports), then decision and strobe.
// The result is a single-cycle strobe; the receiver cannot stall. Synchronous reset
// empties the block and restores the register defaults; no clearing pass is needed.
module two_tick_pattern_locator
   import ttpl_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic signed [POS_BITS-1:0]    rsp_position,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int AW   = $clog2(BUFFER_DEPTH);
   localparam int CW   = AW + 1;
   localparam int AUXW = CW + 1;
   localparam int SW   = ((AW > 16) ? AW : 16) + 2;
   localparam int PW   = SW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_PREP      = 5'b00010,
      ST_BUILD     = 5'b00100,
      ST_SCAN_TICK = 5'b01000,
      ST_SCAN_WIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]            gap_ff, gap_in;
   logic [14:0]            tol_ff, tol_in;
   logic                   gain_ff, gain_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [CW-1:0]          bld_ff, bld_in;
   logic                   bvld_ff, bvld_in;
   logic [AW-1:0]          widx_ff, widx_in;
   logic [CW-1:0]          pre_ff, pre_in;
   logic [CW-1:0]          p_ff, p_in;
   logic                   pend_ff, pend_in;
   logic                   tick_ok_ff, tick_ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic signed [POS_BITS-1:0] rsp_pos_ff, rsp_pos_in;

   logic [SAMPLE_BITS-1:0] smem [BUFFER_DEPTH];
   logic [SAMPLE_BITS-1:0] srd_ff;
   logic [AUXW-1:0]        amem [BUFFER_DEPTH];
   logic [AUXW-1:0]        ard0_ff;
   logic [AUXW-1:0]        ard1_ff;

   logic                   accept;
   logic                   store_en;
   logic [SAMPLE_BITS-1:0] mag_in;
   logic                   reach;
   logic [SW-1:0]          pg;
   logic [SW-1:0]          wa;
   logic [SW-1:0]          wb;
   logic                   in_range;
   logic                   win_on;
   logic                   win_clear;
   logic                   match;
   logic [AW-1:0]          ra0;
   logic [AW-1:0]          ra1;
   logic signed [PW-1:0]   pos_w;
   logic signed [POS_BITS-1:0] pos_clamped;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign store_en     = accept && (fill_ff < DEPTH_C);
   assign mag_in       = req_sample[SAMPLE_BITS-1] ? (~req_sample + 1'b1) : req_sample;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;

   ttpl_reach #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_reach (
      .sample(srd_ff),
      .peak  (peak_ff),
      .gain  (gain_ff),
      .reach (reach)
   );

   assign pg        = SW'(p_ff) + SW'(gap_ff);
   assign wa        = SW'(p_ff) + SW'(tol_ff);
   assign wb        = pg - SW'(tol_ff);
   assign in_range  = pg < SW'(fill_ff);
   assign win_on    = {1'b0, gap_ff} > {1'b0, tol_ff, 1'b0};
   assign win_clear = !win_on || (ard1_ff[CW-1:0] == ard0_ff[CW-1:0]);
   assign match     = tick_ok_ff && win_clear;

   assign pos_w = $signed(PW'(p_ff) - PW'(1) - PW'(tol_ff[14:1]));

   always_comb begin
      if (pos_w < $signed(PW'(POS_NONE))) begin
         pos_clamped = POS_NONE;
      end else if (pos_w > $signed(PW'(POS_MAX))) begin
         pos_clamped = POS_MAX;
      end else begin
         pos_clamped = POS_BITS'(pos_w);
      end
   end

   always_comb begin
      if (state_ff == ST_SCAN_WIN) begin
         ra0 = wa[AW-1:0];
         ra1 = wb[AW-1:0];
      end else begin
         ra0 = p_ff[AW-1:0];
         ra1 = pg[AW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      gap_in       = gap_ff;
      tol_in       = tol_ff;
      gain_in      = gain_ff;
      fill_in      = fill_ff;
      peak_in      = peak_ff;
      bld_in       = bld_ff;
      bvld_in      = 1'b0;
      widx_in      = widx_ff;
      pre_in       = pre_ff;
      p_in         = p_ff;
      pend_in      = pend_ff;
      tick_ok_in   = tick_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TICK_GAP:  gap_in  = csr_wdata;
            CSR_TOLERANCE: tol_in  = csr_wdata[14:0];
            CSR_GAIN:      gain_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (store_en) begin
               fill_in = fill_ff + 1'b1;
               if (mag_in > peak_ff) begin
                  peak_in = mag_in;
               end
            end
            if (accept && req_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (gain_ff && (peak_ff == '0)) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_pos_in   = POS_NONE;
               fill_in      = '0;
               peak_in      = '0;
               state_in     = ST_IDLE;
            end else begin
               bld_in   = '0;
               pre_in   = '0;
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (bvld_ff) begin
               pre_in = pre_ff + CW'(reach);
            end
            if (bld_ff < fill_ff) begin
               bld_in  = bld_ff + 1'b1;
               bvld_in = 1'b1;
               widx_in = bld_ff[AW-1:0];
            end else if (!bvld_ff) begin
               p_in     = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN_TICK;
            end
         end
         ST_SCAN_TICK: begin
            if (pend_ff && match) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = !pos_clamped[POS_BITS-1];
               rsp_pos_in   = pos_clamped;
               fill_in      = '0;
               peak_in      = '0;
               state_in     = ST_IDLE;
            end else if (!in_range) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_pos_in   = POS_NONE;
               fill_in      = '0;
               peak_in      = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SCAN_WIN;
            end
         end
         ST_SCAN_WIN: begin
            tick_ok_in = ard0_ff[AUXW-1] && ard1_ff[AUXW-1];
            p_in       = p_ff + 1'b1;
            pend_in    = 1'b1;
            state_in   = ST_SCAN_TICK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gap_ff       <= RST_TICK_GAP;
         tol_ff       <= RST_TOLERANCE;
         gain_ff      <= RST_GAIN;
         fill_ff      <= '0;
         peak_ff      <= '0;
         bvld_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_ff       <= gap_in;
         tol_ff       <= tol_in;
         gain_ff      <= gain_in;
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
         bvld_ff      <= bvld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bld_ff       <= bld_in;
      widx_ff      <= widx_in;
      pre_ff       <= pre_in;
      p_ff         <= p_in;
      tick_ok_ff   <= tick_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         smem[fill_ff[AW-1:0]] <= req_sample;
      end
      srd_ff <= smem[bld_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (bvld_ff) begin
         amem[widx_ff] <= {reach, pre_ff};
      end
      ard0_ff <= amem[ra0];
      ard1_ff <= amem[ra1];
   end

endmodule

// File: src/ttpl_checker.sv
// Port-level checker for the two-tick pattern locator, bound to the top level.
`timescale 1ns / 1ps
`include "two_tick_pattern_locator_defines.svh"
module ttpl_checker
   import ttpl_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_last,
   input logic                       rsp_valid,
   input logic                       rsp_found,
   input logic signed [POS_BITS-1:0] rsp_position
);

   `TTPL_ASSERT_IMP(a_found_sign, clock, reset, rsp_valid, rsp_found == !rsp_position[POS_BITS-1])
   `TTPL_ASSERT_IMP(a_none_is_minus_one, clock, reset, rsp_valid && !rsp_found, rsp_position == POS_NONE)
   `TTPL_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `TTPL_ASSERT_NXT(a_last_sets_busy, clock, reset, start && !busy && req_last, busy && !rsp_valid)

endmodule

bind two_tick_pattern_locator ttpl_checker u_ttpl_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the two-tick pattern locator: sample blocks, register settings, scoring.
`timescale 1ns / 1ps
module tb;
   import ttpl_pkg::*;

   localparam int SB             = DEF_SAMPLE_BITS;
   localparam int FULL_SCALE     = 1 << (SB - 1);
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 700;

   typedef struct packed {
      logic signed [SB-1:0] sample;
      logic                 last;
   } sample_req_type;

   typedef struct packed {
      logic                       found;
      logic signed [POS_BITS-1:0] position;
   } locate_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [SB-1:0]      req_sample = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_found;
   logic signed [POS_BITS-1:0] rsp_position;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_TICK_GAP;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   sample_req_type    pending_reqs[$];
   locate_result_type expected_hits[$];

   // Shadow of the block: register copies and the magnitudes of the block being loaded.
   logic [15:0]    cfg_gap  = RST_TICK_GAP;
   logic [14:0]    cfg_tol  = RST_TOLERANCE;
   logic           cfg_gain = RST_GAIN;
   int unsigned    blk_mag[$];
   int unsigned    blk_peak = 0;

   bit gaps_on = 1'b1;
   int gap_left = 0;
   int stall_cycles = 0;
   int fail_count = 0;
   int reqs_accepted = 0;
   int blocks_done = 0;
   int results_seen = 0;
   int writes_done = 0;

   two_tick_pattern_locator DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_sample   (req_sample),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic bit reaches_threshold(int unsigned m);
      if (cfg_gain)
         return 9 * longint'(m) >= 7 * longint'(blk_peak);
      return 10 * longint'(m) >= 7 * longint'(FULL_SCALE);
   endfunction

   function automatic longint locate_first_tick();
      int unsigned hit_sum[$];
      longint n, gap, tol, len, lo;
      n = blk_mag.size();
      gap = longint'(cfg_gap);
      tol = longint'(cfg_tol);
      len = gap - 2 * tol;
      if (cfg_gain && blk_peak == 0)
         return -1;
      hit_sum.push_back(0);
      for (int i = 0; i < n; i++)
         hit_sum.push_back(hit_sum[i] + (reaches_threshold(blk_mag[i]) ? 1 : 0));
      for (longint p = 0; p + gap < n; p++) begin
         if (!reaches_threshold(blk_mag[p]) || !reaches_threshold(blk_mag[p + gap]))
            continue;
         if (len > 0) begin
            lo = p + tol;
            if (hit_sum[lo + len] != hit_sum[lo])
               continue;
         end
         return p;
      end
      return -1;
   endfunction

   function automatic void predict_request(logic signed [SB-1:0] s, logic last);
      int unsigned m;
      longint p, pos;
      locate_result_type r;
      m = (s < 0) ? int'(-int'(s)) : int'(s);
      if (blk_mag.size() < DEF_BUFFER_DEPTH) begin
         blk_mag.push_back(m);
         if (m > blk_peak)
            blk_peak = m;
      end
      if (last) begin
         p = locate_first_tick();
         if (p < 0) begin
            pos = -1;
         end else begin
            pos = p - longint'(cfg_tol) / 2;
            if (pos < -1)
               pos = -1;
            if (pos > 65535)
               pos = 65535;
         end
         r.found = (pos >= 0);
         r.position = pos[POS_BITS-1:0];
         expected_hits.push_back(r);
         blk_mag.delete();
         blk_peak = 0;
      end
   endfunction

   function automatic int next_gap();
      int r;
      if (!gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_request(req_sample, req_last);
            reqs_accepted++;
            if (req_last)
               blocks_done++;
            gap_left = next_gap();
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               start <= 1'b0;
               gap_left--;
            end else if (pending_reqs.size() != 0) begin
               sample_req_type item;
               item = pending_reqs.pop_front();
               start      <= 1'b1;
               req_sample <= item.sample;
               req_last   <= item.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_hits.size() == 0) begin
            report_mismatch("unexpected result, position", rsp_position, 0);
         end else begin
            locate_result_type want;
            want = expected_hits.pop_front();
            if (rsp_found !== want.found)
               report_mismatch("found", rsp_found, want.found);
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, want.position);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: errors");
         $finish;
      end
   end

   task automatic add_req(int s, bit last);
      sample_req_type item;
      item.sample = s[SB-1:0];
      item.last = last;
      pending_reqs.push_back(item);
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || start || busy || expected_hits.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TICK_GAP:  cfg_gap = val;
         CSR_TOLERANCE: cfg_tol = val[14:0];
         CSR_GAIN:      cfg_gain = val[0];
         default: ;
      endcase
      writes_done++;
   endtask

   task automatic set_config(int gap, int tol, bit gain);
      write_reg(CSR_TICK_GAP, gap[15:0]);
      write_reg(CSR_TOLERANCE, tol[15:0]);
      write_reg(CSR_GAIN, {15'($urandom_range(0, 32767)), gain});
   endtask

   function automatic int tick_value(int tm);
      if (tm >= FULL_SCALE)
         return -FULL_SCALE;
      return $urandom_range(0, 1) ? tm : -tm;
   endfunction

   // Builds one block and returns the number of requests queued.
   task automatic add_random_block(output int count);
      int vals[$];
      int len, kind, tm, nmax, p, gap, tol, r;
      gap = cfg_gap;
      tol = cfg_tol;
      len = (gap <= 60) ? $urandom_range(1, gap + 24) : $urandom_range(1, 40);
      r = $urandom_range(0, 99);
      kind = (r < 55) ? 1 : (r < 70) ? 2 : (r < 82) ? 3 : 0;
      tm = $urandom_range(23000, FULL_SCALE);
      nmax = tm / 2;
      for (int i = 0; i < len; i++)
         vals.push_back(kind == 0 ? int'($urandom_range(0, 65535))
                                  : int'($urandom_range(0, 2 * nmax)) - nmax);
      p = $urandom_range(0, len - 1);
      if (kind != 0 && len > gap) begin
         p = $urandom_range(0, len - 1 - gap);
         vals[p] = tick_value(tm);
         if (kind != 3)
            vals[p + gap] = tick_value(tm);
         if (kind == 2 && gap > 2 * tol)
            vals[$urandom_range(p + tol, p + gap - tol - 1)] = tick_value(tm);
      end else if (kind == 3) begin
         vals[p] = tick_value(tm);
      end
      for (int i = 0; i < len; i++)
         add_req(vals[i], i == len - 1);
      count = len;
   endtask

   initial begin
      int sent, n, blocks, r, gap, tol;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a single full-scale negative sample, gap far beyond the block.
      add_req(-FULL_SCALE, 1);
      settle();

      // Zero gap: both ticks are the same sample.
      set_config(0, 0, 1'b1);
      add_req(0, 0);
      add_req(32767, 1);
      // Gain on with an all-zero block.
      add_req(0, 0);
      add_req(0, 0);
      add_req(0, 1);
      settle();

      // Absolute threshold, clean window and then a blocked window.
      set_config(4, 1, 1'b0);
      add_req(100, 0);
      add_req(30000, 0);
      add_req(0, 0);
      add_req(0, 0);
      add_req(0, 0);
      add_req(-30000, 0);
      add_req(5, 1);
      add_req(30000, 0);
      add_req(0, 0);
      add_req(25000, 0);
      add_req(0, 0);
      add_req(-30000, 1);
      settle();

      // Empty middle window, and a position that falls below -1.
      set_config(3, 6, 1'b1);
      add_req(32767, 0);
      add_req(0, 0);
      add_req(0, 0);
      add_req(32767, 1);
      settle();

      // Store overflow: full-scale samples past the depth must not count.
      gaps_on = 1'b0;
      set_config(100, 10, 1'b1);
      for (int i = 0; i < DEF_BUFFER_DEPTH; i++)
         add_req((i == 65400 || i == 65500) ? 20000 : int'($urandom_range(0, 4000)) - 2000, 0);
      for (int i = 0; i < 4; i++)
         add_req(-FULL_SCALE, i == 3);
      settle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         gap = (r < 7) ? $urandom_range(1, 24) : (r == 7) ? 0 : (r == 8) ? 65535
                                                            : $urandom_range(25, 60);
         r = $urandom_range(0, 9);
         tol = (r < 7) ? $urandom_range(0, 8) : (r == 7) ? 0 : (r == 8) ? 16'hFFFF
                                                           : $urandom_range(9, 30);
         set_config(gap, tol, $urandom_range(0, 1));
         gaps_on = ($urandom_range(0, 3) != 0);
         blocks = $urandom_range(3, 6);
         for (int b = 0; b < blocks; b++) begin
            add_random_block(n);
            sent += n;
         end
         settle();
      end

      repeat (64) @(posedge clock);
      $display("summary: %0d requests in %0d blocks, %0d results scored, %0d register writes",
               reqs_accepted, blocks_done, results_seen, writes_done);
      $display("summary: gap from 0 to 65535, tolerance from 0 to 32767, both threshold modes");
      if (fail_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
